/* hw/rtl/phase_current_offset_calibrate_filter_unit_macros.svh */
// Assertion macros used by the phase current calibration block checker.
// Needs clk and rst_n in scope at the point of use; no other dependencies.
`ifndef PHASE_CURRENT_OFFSET_CALIBRATE_FILTER_UNIT_MACROS_SVH
`define PHASE_CURRENT_OFFSET_CALIBRATE_FILTER_UNIT_MACROS_SVH

// General property, clocked on clk, switched off while in reset.
`define PCOCF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds while an item waits on a stalled handshake.
`define PCOCF_ASSERT_STALL(lbl, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

/* hw/rtl/pcocf_pkg.sv */
// Shared constants, types and register codes of the phase current calibration block.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package pcocf_pkg;

    localparam int NUM_PHASES    = 3;
    localparam int OFF_FRAC_BITS = 8;
    localparam int CUR_FRAC_BITS = 10;

    localparam int SAMPLE_W    = 12;
    localparam int CUR_W       = 18;
    localparam int COUNT_W     = 16;
    localparam int CENTER_W    = 12;
    localparam int SCALE_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Offset: ADC steps with OFF_FRAC_BITS fraction bits
    localparam int OFF_W = SAMPLE_W + OFF_FRAC_BITS;

    // 9*off + (s << F) + 5 stays below 10 * 2^OFF_W
    localparam int NUM_W    = OFF_W + 4;
    // divide by ten as multiply by ceil(2^k/10); exact for all NUM_W-bit values
    localparam int DIV_K    = NUM_W + 4;
    localparam int DIV_M_W  = DIV_K - 2;
    localparam longint unsigned DIV_M = ((64'd1 << DIV_K) + 64'd9) / 64'd10;
    localparam int DIV_P_W  = NUM_W + DIV_M_W;

    // Current filter datapath
    localparam int DIFF_W    = OFF_W + 1;
    localparam int CUR_SHIFT = OFF_FRAC_BITS + SCALE_W - CUR_FRAC_BITS;
    localparam int PROD_W    = DIFF_W + SCALE_W + 1;
    localparam int ACC_W     = ((PROD_W > CUR_W + CUR_SHIFT) ? PROD_W
                                                             : CUR_W + CUR_SHIFT) + 2;
    localparam int FILT_W    = ACC_W - CUR_SHIFT - 1;

    localparam int CUR_MAX_INT = 2 ** (CUR_W - 1) - 1;
    localparam int CUR_MIN_INT = -(2 ** (CUR_W - 1));

    localparam logic [COUNT_W-1:0]  RST_CAL_SAMPLES = COUNT_W'(2000);
    localparam logic [CENTER_W-1:0] RST_OFF_CENTER  = CENTER_W'(2048);
    localparam logic [CENTER_W-1:0] RST_OFF_TOL     = CENTER_W'(100);
    localparam logic [SCALE_W-1:0]  RST_CUR_SCALE   = SCALE_W'(1886);

    typedef logic [SAMPLE_W-1:0]       sample_t;
    typedef logic [OFF_W-1:0]          offset_t;
    typedef logic signed [CUR_W-1:0]   current_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CAL_SAMPLES = CFG_INDEX_W'(0),
        REG_OFF_CENTER  = CFG_INDEX_W'(1),
        REG_OFF_TOL     = CFG_INDEX_W'(2),
        REG_CUR_SCALE   = CFG_INDEX_W'(3)
    } cfg_reg_t;

endpackage

`default_nettype wire

/* hw/rtl/pcocf_sample_if.sv */
// Valid/ready channel carrying one three-phase ADC sample item.
// Depends on pcocf_pkg.
`default_nettype none

interface pcocf_sample_if;
    import pcocf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_phase_a;
    sample_t sample_phase_b;
    sample_t sample_phase_c;

    modport source (output valid, output sample_phase_a, output sample_phase_b,
                    output sample_phase_c, input ready);
    modport sink   (input valid, input sample_phase_a, input sample_phase_b,
                    input sample_phase_c, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pcocf_current_if.sv */
// Valid/ready channel carrying one filtered three-phase current item.
// Depends on pcocf_pkg.
`default_nettype none

interface pcocf_current_if;
    import pcocf_pkg::*;

    logic     valid;
    logic     ready;
    current_t current_phase_a;
    current_t current_phase_b;
    current_t current_phase_c;
    logic     offset_error;

    modport source (output valid, output current_phase_a, output current_phase_b,
                    output current_phase_c, output offset_error, input ready);
    modport sink   (input valid, input current_phase_a, input current_phase_b,
                    input current_phase_c, input offset_error, output ready);
endinterface

`default_nettype wire

/* hw/rtl/phase_current_offset_calibrate_filter_unit.sv */
// Phase current offset calibration and filter: top level.
// Depends on pcocf_pkg, pcocf_sample_if and pcocf_current_if.
`default_nettype none

// The block takes one three-phase ADC sample item per cycle, back to back, for as
// long as the result side keeps up. The first calibration_samples items teach a
// zero-current offset per phase (offset = 0.9*offset + 0.1*sample, 8 fraction
// bits) and give no result. The first item after that checks the offsets once
// against offset_center +/- offset_tolerance and latches offset_error until reset;
// it and every later item give one result: three currents in 1/1024 A, each the
// saturated average of the previous current and (sample - offset) * current_scale.
// An accepted item is worked while it sits in the input register, and its result
// is loaded from there into the result register, where it is held until taken. The
// figure of one item a cycle is set by the state update (divide-by-ten offset
// filter, or multiply-add current filter) that closes its loop combinationally
// between the input register and the state/result registers. A full result
// register that is not taken stalls only items that produce a result; calibration
// items keep flowing. Write the configuration registers only while the block is
// idle.
module phase_current_offset_calibrate_filter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [pcocf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pcocf_pkg::CFG_DATA_W-1:0]    cfg_data,
    pcocf_sample_if.sink                        samples,
    pcocf_current_if.source                     currents
);
    import pcocf_pkg::*;

    localparam logic [DIV_M_W-1:0] DIV_M_VEC = DIV_M_W'(DIV_M);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< CUR_SHIFT;
    localparam logic signed [FILT_W-1:0] FILT_MAX = FILT_W'(CUR_MAX_INT);
    localparam logic signed [FILT_W-1:0] FILT_MIN = FILT_W'(CUR_MIN_INT);

    // Configuration registers
    logic [COUNT_W-1:0]  cal_samples_reg;
    logic [CENTER_W-1:0] off_center_reg;
    logic [CENTER_W-1:0] off_tol_reg;
    logic [SCALE_W-1:0]  cur_scale_reg;

    // Block state
    logic [COUNT_W-1:0] cal_count_reg;
    offset_t            offset_reg [NUM_PHASES];
    logic               checked_reg;
    logic               error_reg;
    current_t           filt_reg   [NUM_PHASES];

    // Input register
    logic    s1_valid_reg;
    sample_t s1_sample_reg [NUM_PHASES];

    // Result register
    logic     out_valid_reg;
    current_t out_cur_reg [NUM_PHASES];
    logic     out_err_reg;

    // Datapath
    logic                     calibrating;
    logic                     out_free;
    logic                     s1_advance;
    logic                     in_accept;
    logic [NUM_W-1:0]         num       [NUM_PHASES];
    logic [DIV_P_W-1:0]       quot_prod [NUM_PHASES];
    offset_t                  offset_next [NUM_PHASES];
    logic signed [DIFF_W-1:0] diff      [NUM_PHASES];
    logic signed [PROD_W-1:0] prod      [NUM_PHASES];
    logic signed [ACC_W-1:0]  acc       [NUM_PHASES];
    logic signed [ACC_W-1:0]  acc_shr   [NUM_PHASES];
    logic signed [FILT_W-1:0] filt_full [NUM_PHASES];
    current_t                 filt_next [NUM_PHASES];
    logic [CENTER_W:0]        hi_bound;
    logic [CENTER_W:0]        lo_bound;
    logic                     bad_any;
    logic                     error_next;

    // -------------------------------------------------------------------------
    // Handshake: the input register moves on when its item gives no result or
    // the result register has room.
    // -------------------------------------------------------------------------
    assign calibrating   = cal_count_reg < cal_samples_reg;
    assign out_free      = !out_valid_reg || currents.ready;
    assign s1_advance    = s1_valid_reg && (calibrating || out_free);
    assign samples.ready = !s1_valid_reg || s1_advance;
    assign in_accept     = samples.valid && samples.ready;

    // -------------------------------------------------------------------------
    // Per-phase arithmetic
    // -------------------------------------------------------------------------
    always_comb
    begin
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // offset' = floor((9*off + (s << F) + 5) / 10)
            num[p] = (NUM_W'(offset_reg[p]) << 3) + NUM_W'(offset_reg[p])
                   + NUM_W'({s1_sample_reg[p], {OFF_FRAC_BITS{1'b0}}}) + NUM_W'(5);
            quot_prod[p]   = DIV_P_W'(num[p]) * DIV_P_W'(DIV_M_VEC);
            offset_next[p] = quot_prod[p][DIV_K +: OFF_W];

            // current' = sat(floor(((cur << S) + d*scale + 2^S) / 2^(S+1)))
            diff[p] = signed'({1'b0, s1_sample_reg[p], {OFF_FRAC_BITS{1'b0}}})
                    - signed'({1'b0, offset_reg[p]});
            prod[p] = PROD_W'(diff[p]) * PROD_W'(signed'({1'b0, cur_scale_reg}));
            acc[p]  = (ACC_W'(filt_reg[p]) <<< CUR_SHIFT) + ACC_W'(prod[p]) + ROUND_HALF;
            acc_shr[p]   = acc[p] >>> (CUR_SHIFT + 1);
            filt_full[p] = signed'(acc_shr[p][FILT_W-1:0]);
            if (filt_full[p] > FILT_MAX)
            begin
                filt_next[p] = CUR_W'(CUR_MAX_INT);
            end
            else if (filt_full[p] < FILT_MIN)
            begin
                filt_next[p] = CUR_W'(CUR_MIN_INT);
            end
            else
            begin
                filt_next[p] = filt_full[p][CUR_W-1:0];
            end
        end
    end

    // -------------------------------------------------------------------------
    // One-off offset check. A negative lower bound lets nothing fall below it.
    // -------------------------------------------------------------------------
    assign hi_bound = {1'b0, off_center_reg} + {1'b0, off_tol_reg};
    assign lo_bound = {1'b0, off_center_reg} - {1'b0, off_tol_reg};

    always_comb
    begin
        bad_any = 1'b0;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if ({1'b0, offset_reg[p]} > {hi_bound, {OFF_FRAC_BITS{1'b0}}})
            begin
                bad_any = 1'b1;
            end
            if (!lo_bound[CENTER_W] &&
                (offset_reg[p] < {lo_bound[CENTER_W-1:0], {OFF_FRAC_BITS{1'b0}}}))
            begin
                bad_any = 1'b1;
            end
        end
        error_next = checked_reg ? error_reg : bad_any;
    end

    // -------------------------------------------------------------------------
    // Configuration registers
    // -------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_samples_reg <= RST_CAL_SAMPLES;
            off_center_reg  <= RST_OFF_CENTER;
            off_tol_reg     <= RST_OFF_TOL;
            cur_scale_reg   <= RST_CUR_SCALE;
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAL_SAMPLES: cal_samples_reg <= cfg_data[COUNT_W-1:0];
                REG_OFF_CENTER:  off_center_reg  <= cfg_data[CENTER_W-1:0];
                REG_OFF_TOL:     off_tol_reg     <= cfg_data[CENTER_W-1:0];
                REG_CUR_SCALE:   cur_scale_reg   <= cfg_data[SCALE_W-1:0];
                default:         ; // unknown index, write dropped
            endcase
        end
    end

    // -------------------------------------------------------------------------
    // Control and block state
    // -------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cal_count_reg <= '0;
            checked_reg   <= 1'b0;
            error_reg     <= 1'b0;
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                offset_reg[p] <= '0;
                filt_reg[p]   <= '0;
            end
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance && !calibrating)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (currents.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                if (calibrating)
                begin
                    cal_count_reg <= cal_count_reg + COUNT_W'(1);
                    for (int p = 0; p < NUM_PHASES; p++)
                    begin
                        offset_reg[p] <= offset_next[p];
                    end
                end
                else
                begin
                    checked_reg <= 1'b1;
                    error_reg   <= error_next;
                    for (int p = 0; p < NUM_PHASES; p++)
                    begin
                        filt_reg[p] <= filt_next[p];
                    end
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // Payload registers
    // -------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg[0] <= samples.sample_phase_a;
            s1_sample_reg[1] <= samples.sample_phase_b;
            s1_sample_reg[2] <= samples.sample_phase_c;
        end
        if (s1_advance && !calibrating)
        begin
            out_err_reg <= error_next;
            for (int p = 0; p < NUM_PHASES; p++)
            begin
                out_cur_reg[p] <= filt_next[p];
            end
        end
    end

    assign currents.valid           = out_valid_reg;
    assign currents.current_phase_a = out_cur_reg[0];
    assign currents.current_phase_b = out_cur_reg[1];
    assign currents.current_phase_c = out_cur_reg[2];
    assign currents.offset_error    = out_err_reg;

endmodule

`default_nettype wire

/* hw/rtl/pcocf_checker.sv */
// Port-level checker for the phase current calibration block, and its bind.
// Depends on pcocf_pkg and the assertion macro header.
`default_nettype none
`include "phase_current_offset_calibrate_filter_unit_macros.svh"

module pcocf_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input pcocf_pkg::current_t   out_current_a,
    input pcocf_pkg::current_t   out_current_b,
    input pcocf_pkg::current_t   out_current_c,
    input logic                  out_error
);
    import pcocf_pkg::*;

    logic [3*CUR_W:0] out_payload;

    assign out_payload = {out_current_a, out_current_b, out_current_c, out_error};

    // With an empty result register nothing can hold the input side back.
    `PCOCF_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with no result pending")

    // The offset check runs once, so back-to-back results carry the same flag.
    `PCOCF_ASSERT(a_error_steady, (out_valid && out_ready) ##1 out_valid |-> out_error == $past(out_error), "offset_error changed between results")

    `PCOCF_ASSERT_STALL(a_valid_held, out_valid, out_ready, out_valid, "result valid dropped while stalled")

    `PCOCF_ASSERT_STALL(a_payload_held, out_valid, out_ready, out_payload, "result changed while stalled")

    // in_valid is part of the port view but carries no property of its own here
    logic unused_in_valid;
    assign unused_in_valid = in_valid;

endmodule

bind phase_current_offset_calibrate_filter_unit pcocf_checker u_pcocf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (samples.valid),
    .in_ready      (samples.ready),
    .out_valid     (currents.valid),
    .out_ready     (currents.ready),
    .out_current_a (currents.current_phase_a),
    .out_current_b (currents.current_phase_b),
    .out_current_c (currents.current_phase_c),
    .out_error     (currents.offset_error)
);

`default_nettype wire
